// ===== rtl/diagonal_peano_curve_walker_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef DIAGONAL_PEANO_CURVE_WALKER_MACROS_SVH
`define DIAGONAL_PEANO_CURVE_WALKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, clocked on clk, off during reset.
`define DPCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define DPCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define DPCW_ASSERT_NOW(label, ante, cons)
`define DPCW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/dpcw_pkg.sv =====
package dpcw_pkg;

  localparam int MAX_DEPTH = 8;
  localparam int DEPTH_W   = 5;   // holds 0..MAX_DEPTH, MAX_DEPTH up to 31
  localparam int COORD_W   = 12;
  localparam int HEAD_W    = 6;
  localparam int DIGIT_W   = 4;
  localparam int COLOR_W   = 8;

  localparam logic [COORD_W-1:0] COORD_MAX     = '1;
  localparam logic [HEAD_W-1:0]  HEADING_MOD   = 6'd36;
  localparam logic [HEAD_W-1:0]  HEADING_LAST  = 6'd35;
  localparam logic [HEAD_W-1:0]  HEADING_START = 6'd28;  // 1000 mod 36
  localparam logic [DIGIT_W-1:0] DIGIT_TOP     = 4'd8;

  typedef enum logic [1:0] {
    REG_CURVE_DEPTH = 2'd0,
    REG_STEP_LENGTH = 2'd1,
    REG_START_X     = 2'd2,
    REG_START_Y     = 2'd3
  } cfg_reg_t;

  // heading mod 4
  typedef enum logic [1:0] {
    MOVE_PX_PY = 2'd0,
    MOVE_PX_NY = 2'd1,
    MOVE_NX_NY = 2'd2,
    MOVE_NX_PY = 2'd3
  } move_t;

  localparam logic [COLOR_W-1:0] RED_TAB [9] =
    '{8'd0, 8'd85, 8'd170, 8'd255, 8'd170, 8'd85, 8'd0, 8'd0, 8'd0};
  localparam logic [COLOR_W-1:0] GREEN_TAB [9] =
    '{8'd255, 8'd170, 8'd85, 8'd0, 8'd0, 8'd0, 8'd0, 8'd85, 8'd170};
  localparam logic [COLOR_W-1:0] BLUE_TAB [9] =
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd85, 8'd170, 8'd255, 8'd170, 8'd85};

  // 1: turn +1, 0: turn -1, by digit value before it advances
  localparam logic [7:0] TURN_UP = 8'b1000_1110;

  function automatic logic [3:0] heading_mod9(logic [HEAD_W-1:0] h);
    logic [HEAD_W-1:0] r;
    begin
      r = h;
      if (r >= 6'd27) begin
        r = r - 6'd27;
      end else if (r >= 6'd18) begin
        r = r - 6'd18;
      end else if (r >= 6'd9) begin
        r = r - 6'd9;
      end
      return r[3:0];
    end
  endfunction

  function automatic logic [COORD_W-1:0] sat_add(logic [COORD_W-1:0] a,
                                                 logic [COORD_W-1:0] b);
    logic [COORD_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      return s[COORD_W] ? COORD_MAX : s[COORD_W-1:0];
    end
  endfunction

  function automatic logic [COORD_W-1:0] sat_sub(logic [COORD_W-1:0] a,
                                                 logic [COORD_W-1:0] b);
    begin
      return (b > a) ? '0 : a - b;
    end
  endfunction

endpackage

// ===== rtl/diagonal_peano_curve_walker.sv =====
// Diagonal Peano curve walker.
// Input channel (item_valid / item_stall, field restart): each transfer asks
// for one segment. restart=1 starts a new curve at (start_x, start_y) and
// emits its first segment; restart=0 emits the next segment, or nothing
// when no curve is running (before any restart or after the last segment).
// Output channel (result_valid / result_stall): segment endpoints, color
// and a last_segment flag; a curve of depth d has 9**d segments.
// A result is in the output register the cycle after its item is taken.
// Throughput is one item per cycle while item_stall is low; the digit carry,
// heading turn and saturating position add all sit between the state
// registers and the output register.
// item_stall is raised only while a result is held and the receiver stalls;
// otherwise the output register is refilled in the cycle it is drained.
// Configuration (wr_en, wr_index, wr_data) is written while idle; curve_depth
// above MAX_DEPTH acts as MAX_DEPTH.
// rst (synchronous) restores register defaults, clears result_valid
// and leaves the walker idle until a restart.
`include "diagonal_peano_curve_walker_macros.svh"

module diagonal_peano_curve_walker
  import dpcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [COORD_W-1:0] wr_data,

  input  logic               item_valid,
  output logic               item_stall,
  input  logic               restart,

  output logic               result_valid,
  input  logic               result_stall,
  output logic [COORD_W-1:0] from_x,
  output logic [COORD_W-1:0] from_y,
  output logic [COORD_W-1:0] to_x,
  output logic [COORD_W-1:0] to_y,
  output logic [COLOR_W-1:0] red,
  output logic [COLOR_W-1:0] green,
  output logic [COLOR_W-1:0] blue,
  output logic               last_segment
);

  // configuration
  logic [DIGIT_W-1:0] curve_depth;
  logic [COORD_W-1:0] step_length;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;

  // walker state
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [HEAD_W-1:0]  heading;
  logic [DIGIT_W-1:0] digits [MAX_DEPTH];
  logic               running;

  logic [COORD_W-1:0] pos_x_next;
  logic [COORD_W-1:0] pos_y_next;
  logic [HEAD_W-1:0]  heading_next;
  logic [DIGIT_W-1:0] digits_next [MAX_DEPTH];
  logic               running_next;

  logic               item_take;
  logic               emit;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [HEAD_W-1:0]  cur_heading;
  logic [DIGIT_W-1:0] cur_digits [MAX_DEPTH];
  logic [COORD_W-1:0] nx;
  logic [COORD_W-1:0] ny;
  logic [3:0]         color_idx;
  logic [DEPTH_W-1:0] depth_act;
  logic [MAX_DEPTH-1:0] eligible;
  logic [MAX_DEPTH-1:0] first;
  logic [MAX_DEPTH-1:0] seen;
  logic               found;
  logic               turn_up;
  move_t              move;

  assign item_stall = result_valid && result_stall;
  assign item_take  = item_valid && !item_stall;
  assign emit       = restart || running;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_depth <= '0;
      step_length <= COORD_W'(1);
      start_x     <= '0;
      start_y     <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_CURVE_DEPTH: curve_depth <= wr_data[DIGIT_W-1:0];
        REG_STEP_LENGTH: step_length <= wr_data;
        REG_START_X:     start_x     <= wr_data;
        REG_START_Y:     start_y     <= wr_data;
        default: ;
      endcase
    end
  end

  // starting point of this segment: fresh curve or current state
  always_comb begin
    cur_x       = restart ? start_x : pos_x;
    cur_y       = restart ? start_y : pos_y;
    cur_heading = restart ? HEADING_START : heading;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      cur_digits[i] = restart ? '0 : digits[i];
    end
  end

  always_comb begin
    move = move_t'(cur_heading[1:0]);
    nx   = cur_x;
    ny   = cur_y;
    case (move)
      MOVE_PX_PY: begin
        nx = sat_add(cur_x, step_length);
        ny = sat_add(cur_y, step_length);
      end
      MOVE_PX_NY: begin
        nx = sat_add(cur_x, step_length);
        ny = sat_sub(cur_y, step_length);
      end
      MOVE_NX_NY: begin
        nx = sat_sub(cur_x, step_length);
        ny = sat_sub(cur_y, step_length);
      end
      default: begin
        nx = sat_sub(cur_x, step_length);
        ny = sat_add(cur_y, step_length);
      end
    endcase
    color_idx = heading_mod9(cur_heading);
  end

  // base-9 counter: lowest active digit below 8 advances, lower ones wrap
  always_comb begin
    depth_act = ({1'b0, curve_depth} > DEPTH_W'(MAX_DEPTH)) ?
                DEPTH_W'(MAX_DEPTH) : {1'b0, curve_depth};
    for (int i = 0; i < MAX_DEPTH; i++) begin
      eligible[i] = (DEPTH_W'(i) < depth_act) && (cur_digits[i] < DIGIT_TOP);
    end
    seen[0]  = eligible[0];
    first[0] = eligible[0];
    for (int i = 1; i < MAX_DEPTH; i++) begin
      first[i] = eligible[i] && !seen[i-1];
      seen[i]  = eligible[i] || seen[i-1];
    end
    found   = seen[MAX_DEPTH-1];
    turn_up = 1'b0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (first[i]) begin
        turn_up = TURN_UP[cur_digits[i][2:0]];
      end
    end
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (first[i]) begin
        digits_next[i] = cur_digits[i] + DIGIT_W'(1);
      end else if (found && !seen[i]) begin
        digits_next[i] = '0;
      end else begin
        digits_next[i] = cur_digits[i];
      end
    end
    if (!found) begin
      heading_next = cur_heading;
    end else if (turn_up) begin
      heading_next = (cur_heading == HEADING_LAST) ? '0 : cur_heading + HEAD_W'(1);
    end else begin
      heading_next = (cur_heading == '0) ? HEADING_LAST : cur_heading - HEAD_W'(1);
    end
    pos_x_next   = nx;
    pos_y_next   = ny;
    running_next = found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      heading <= HEADING_START;
      running <= 1'b0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
        digits[i] <= '0;
      end
    end else if (item_take && emit) begin
      pos_x   <= pos_x_next;
      pos_y   <= pos_y_next;
      heading <= heading_next;
      running <= running_next;
      for (int i = 0; i < MAX_DEPTH; i++) begin
        digits[i] <= digits_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_take && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      from_x       <= cur_x;
      from_y       <= cur_y;
      to_x         <= nx;
      to_y         <= ny;
      red          <= RED_TAB[color_idx];
      green        <= GREEN_TAB[color_idx];
      blue         <= BLUE_TAB[color_idx];
      last_segment <= !found;
    end
  end

  `DPCW_ASSERT_NOW(a_heading_range, 1'b1, heading < HEADING_MOD)
  `DPCW_ASSERT_NEXT(a_last_stops, item_take && emit && !found,
                    !running && result_valid && last_segment)
  `DPCW_ASSERT_NEXT(a_idle_no_result, item_take && !emit, !result_valid)
  `DPCW_ASSERT_NEXT(a_restart_origin, item_take && restart,
                    result_valid && from_x == $past(start_x) && from_y == $past(start_y))
  `DPCW_ASSERT_NOW(a_digit_range, 1'b1, digits[0] <= DIGIT_TOP)

endmodule
